### rtl/core/ptaq_pkg.sv
// Shared types and constants for the parent table ancestor query block.
// Used by ptaq_step and the top level under rtl/core; depends on nothing.
package ptaq_pkg;

   // Field widths fixed by the request and response formats
   localparam int FUNC_BITS   = 3;
   localparam int NODE_BITS   = 10;
   localparam int ID_BITS     = 16;
   localparam int STATUS_BITS = 2;

   // Defaults for top-level parameters
   localparam int DEF_TABLE_DEPTH  = 1024;
   localparam int DEF_ELEMENT_BITS = 16;

   // Function codes
   localparam logic [FUNC_BITS-1:0] FN_APPEND   = 3'd0;
   localparam logic [FUNC_BITS-1:0] FN_CLEAR    = 3'd1;
   localparam logic [FUNC_BITS-1:0] FN_DEPTH    = 3'd2;
   localparam logic [FUNC_BITS-1:0] FN_ANCESTOR = 3'd3;
   localparam logic [FUNC_BITS-1:0] FN_ROOT     = 3'd4;
   localparam logic [FUNC_BITS-1:0] FN_CONTAINS = 3'd5;

   // Status codes
   localparam logic [STATUS_BITS-1:0] STAT_OK         = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_NOT_LOADED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_FULL       = 2'd2;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic [NODE_BITS-1:0] node_a;
      logic [NODE_BITS-1:0] node_b;
      logic [ID_BITS-1:0]   element_id;
   } req_type;

   typedef struct packed {
      logic [NODE_BITS-1:0]   value;
      logic                   answer;
      logic [STATUS_BITS-1:0] status;
   } rsp_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Walk step unit: operands in, decision and next operands out
   typedef struct packed {
      logic                 update;   // 0: test for end, 1: apply parent read
      logic [FUNC_BITS-1:0] func;
      logic [NODE_BITS-1:0] node_a;
      logic [NODE_BITS-1:0] node_b;
      logic [NODE_BITS-1:0] depth;
      logic [NODE_BITS-1:0] parent;
      logic                 elem_hit;
   } step_in_type;

   typedef struct packed {
      logic                 done;
      logic                 answer;
      logic [NODE_BITS-1:0] value;
      logic                 sel_b;    // walk pointer is node_b
      logic [NODE_BITS-1:0] node_a;
      logic [NODE_BITS-1:0] node_b;
      logic [NODE_BITS-1:0] depth;
   } step_out_type;

endpackage

### rtl/core/ptaq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module ptaq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/ptaq_step.sv
// Shared compare/increment unit for one level of a parent-link walk.
// Depends on ptaq_pkg for function codes and the step structs.
module ptaq_step (
   input  ptaq_pkg::step_in_type  step_in,
   output ptaq_pkg::step_out_type step_out
);
   import ptaq_pkg::*;

   logic a_eq_b;
   logic a_lt_b;
   logic a_zero;

   // Comparators shared by all walk types
   assign a_eq_b = (step_in.node_a == step_in.node_b);
   assign a_lt_b = (step_in.node_a <  step_in.node_b);
   assign a_zero = (step_in.node_a == '0);

   always_comb begin
      step_out        = '0;
      step_out.node_a = step_in.node_a;
      step_out.node_b = step_in.node_b;
      step_out.depth  = step_in.depth;

      unique case (step_in.func)
         FN_DEPTH: begin
            if (!step_in.update) begin
               step_out.done  = a_zero;
               step_out.value = step_in.depth;
            end else begin
               step_out.node_a = step_in.parent;
               step_out.depth  = step_in.depth + NODE_BITS'(1);
            end
         end
         FN_ANCESTOR: begin
            // Walk b upward until it meets a or drops below it
            if (!step_in.update) begin
               if (a_zero || a_eq_b) begin
                  step_out.done   = 1'b1;
                  step_out.answer = 1'b1;
               end else if (!a_lt_b) begin
                  step_out.done = 1'b1;
               end
               step_out.sel_b = 1'b1;
            end else begin
               step_out.node_b = step_in.parent;
            end
         end
         FN_ROOT: begin
            // Raise whichever index is larger
            if (!step_in.update) begin
               step_out.done  = a_eq_b;
               step_out.value = step_in.node_a;
               step_out.sel_b = a_lt_b;
            end else if (a_lt_b) begin
               step_out.node_b = step_in.parent;
            end else begin
               step_out.node_a = step_in.parent;
            end
         end
         FN_CONTAINS: begin
            // Root element is never compared
            if (!step_in.update) begin
               step_out.done = a_zero;
            end else if (step_in.elem_hit) begin
               step_out.done   = 1'b1;
               step_out.answer = 1'b1;
            end else begin
               step_out.node_a = step_in.parent;
            end
         end
         default: begin
            step_out.done = 1'b1;
         end
      endcase
   end

endmodule

### rtl/core/parent_table_ancestor_query.sv
// Parent table ancestor query: top level with sequencer and node tables.
// Depends on ptaq_pkg, ptaq_ram and ptaq_step.
//
// Usage:
//   Requests arrive on req_valid/req_stall/req_data; one response per request
//   leaves on rsp_valid/rsp_stall/rsp_data. A transfer happens on a clock
//   edge with valid high and stall low.
//   Append, clear, unused codes and any request naming an unloaded index
//   go straight from acceptance to the finish state. Walking queries visit
//   one parent level per check/update pair (one parent table read, one
//   update through the shared step unit), and common root raises the larger
//   index on either side at each level.
//   The block takes one request at a time: req_stall is high from
//   acceptance until the response is loaded into the output register.
//   The output register lets a new request be accepted while the previous
//   response is still held by a stalling receiver; a finished result then
//   waits in the sequencer until the output register frees up.
//   Reset leaves only the root loaded (node count 1) and clears all
//   handshake state; table contents need no clearing pass.
module parent_table_ancestor_query #(
   parameter int TABLE_DEPTH  = ptaq_pkg::DEF_TABLE_DEPTH,
   parameter int ELEMENT_BITS = ptaq_pkg::DEF_ELEMENT_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ptaq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptaq_pkg::rsp_type rsp_data
);
   import ptaq_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // Control state
   state_type            state_ff,   state_in;
   logic [CW-1:0]        count_ff,   count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // Payload registers
   rsp_type              rsp_data_ff, rsp_data_in;
   rsp_type              res_ff,     res_in;
   logic [FUNC_BITS-1:0] func_ff,    func_in;
   logic [NODE_BITS-1:0] a_ff,       a_in;
   logic [NODE_BITS-1:0] b_ff,       b_in;
   logic [NODE_BITS-1:0] depth_ff,   depth_in;
   logic [ELEMENT_BITS-1:0] key_ff,  key_in;

   // Table ports
   logic                    wr_en;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [NODE_BITS-1:0]    parent_rd;
   logic [ELEMENT_BITS-1:0] elem_rd;
   logic [ELEMENT_BITS-1:0] req_key;

   step_in_type  step_in;
   step_out_type step_out;

   logic accept;
   logic a_loaded;
   logic b_loaded;
   logic table_full;
   logic rsp_free;

   assign accept     = req_valid && !req_stall;
   assign req_key    = ELEMENT_BITS'(req_data.element_id);
   assign a_loaded   = (32'(req_data.node_a) < 32'(count_ff));
   assign b_loaded   = (32'(req_data.node_b) < 32'(count_ff));
   assign table_full = (count_ff == CW'(TABLE_DEPTH));
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign wr_en = accept && (req_data.func == FN_APPEND) && a_loaded && !table_full;

   // Node tables: parent index and element id per entry
   ptaq_ram #(
      .WIDTH (NODE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(count_ff)),
      .wr_data (req_data.node_a),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (parent_rd)
   );

   ptaq_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_element_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(count_ff)),
      .wr_data (req_key),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (elem_rd)
   );

   // Shared walk step unit
   always_comb begin
      step_in          = '0;
      step_in.update   = (state_ff == ST_UPDATE);
      step_in.func     = func_ff;
      step_in.node_a   = a_ff;
      step_in.node_b   = b_ff;
      step_in.depth    = depth_ff;
      step_in.parent   = parent_rd;
      step_in.elem_hit = (elem_rd == key_ff);
   end

   ptaq_step u_step (
      .step_in  (step_in),
      .step_out (step_out)
   );

   assign rd_en   = (state_ff == ST_CHECK) && !step_out.done;
   assign rd_addr = step_out.sel_b ? AW'(b_ff) : AW'(a_ff);

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      func_ff     <= func_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      depth_ff    <= depth_in;
      key_ff      <= key_in;
   end

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      res_in       = res_ff;
      func_in      = func_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      depth_in     = depth_ff;
      key_in       = key_ff;
      req_stall    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               func_in  = req_data.func;
               a_in     = req_data.node_a;
               b_in     = req_data.node_b;
               key_in   = req_key;
               depth_in = '0;
               res_in   = '0;
               state_in = ST_FINISH;
               unique case (req_data.func)
                  FN_APPEND: begin
                     if (!a_loaded) begin
                        res_in.status = STAT_NOT_LOADED;
                     end else if (table_full) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        res_in.value = NODE_BITS'(count_ff);
                        count_in     = count_ff + CW'(1);
                     end
                  end
                  FN_CLEAR: begin
                     count_in = CW'(1);
                  end
                  FN_DEPTH, FN_CONTAINS: begin
                     if (!a_loaded) begin
                        res_in.status = STAT_NOT_LOADED;
                     end else begin
                        state_in = ST_CHECK;
                     end
                  end
                  FN_ANCESTOR, FN_ROOT: begin
                     if (!a_loaded || !b_loaded) begin
                        res_in.status = STAT_NOT_LOADED;
                     end else begin
                        state_in = ST_CHECK;
                     end
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (step_out.done) begin
               res_in.value  = step_out.value;
               res_in.answer = step_out.answer;
               res_in.status = STAT_OK;
               state_in      = ST_FINISH;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (step_out.done) begin
               res_in.value  = step_out.value;
               res_in.answer = step_out.answer;
               res_in.status = STAT_OK;
               state_in      = ST_FINISH;
            end else begin
               a_in     = step_out.node_a;
               b_in     = step_out.node_b;
               depth_in = step_out.depth;
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            // Hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
